### rtl/core/stx_frame_builder_xor_lrc_assert.svh
// Assertion macros for the frame builder checker.
`ifndef STX_FRAME_BUILDER_XOR_LRC_ASSERT_SVH
`define STX_FRAME_BUILDER_XOR_LRC_ASSERT_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define STXF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define STXF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/stxf_pkg.sv
// Package with the shared types and constants of the STX frame builder.
`default_nettype none

package stxf_pkg;

	typedef logic [7:0] byte_t;

	localparam byte_t STX_BYTE = 8'h02;

	// Width of the payload length and of the bytes-remaining counter.
	localparam int LEN_W = 13;

	// Most bytes a single input item can produce (header plus closing LRC).
	localparam int BURST_DEPTH = 5;
	localparam int CNT_W = 3;

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_DATA  = 1'b1
	} action_t;

	typedef struct packed {
		logic [CNT_W-1:0]         count;
		byte_t [BURST_DEPTH-1:0]  bytes;
		logic [BURST_DEPTH-1:0]   ends;
	} burst_t;

endpackage

`default_nettype wire

### rtl/core/stxf_in_if.sv
// Input channel of the frame builder: start and data items.
`default_nettype none

interface stxf_in_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [7:0]  command;
	logic [15:0] frame_length;
	logic        payload_absent;
	logic [7:0]  data_byte;

	modport source (
		output valid, action, command, frame_length, payload_absent, data_byte,
		input  ready
	);
	modport sink (
		input  valid, action, command, frame_length, payload_absent, data_byte,
		output ready
	);
endinterface

`default_nettype wire

### rtl/core/stxf_out_if.sv
// Output channel of the frame builder: one frame byte per beat.
`default_nettype none

interface stxf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       frame_end;

	modport source (
		output valid, out_byte, frame_end,
		input  ready
	);
	modport sink (
		input  valid, out_byte, frame_end,
		output ready
	);
endinterface

`default_nettype wire

### rtl/core/stxf_byte_queue.sv
// Burst buffer that serializes the bytes of one item onto a registered output.
`default_nettype none

module stxf_byte_queue (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   load,
	input  wire stxf_pkg::burst_t load_burst,
	output logic                  free,
	stxf_out_if.source            frame
);

	logic [stxf_pkg::CNT_W-1:0]                cnt_s2;
	stxf_pkg::byte_t [stxf_pkg::BURST_DEPTH-1:0] bytes_s2;
	logic [stxf_pkg::BURST_DEPTH-1:0]          ends_s2;

	logic            out_valid_s3;
	stxf_pkg::byte_t out_byte_s3;
	logic            frame_end_s3;

	logic pop;

	// The head byte moves into the output register whenever that register is empty
	// or is being taken in this cycle.
	assign pop  = (cnt_s2 != '0) && (!out_valid_s3 || frame.ready);
	assign free = (cnt_s2 == '0) || ((cnt_s2 == stxf_pkg::CNT_W'(1)) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2       <= '0;
			out_valid_s3 <= 1'b0;
		end else begin
			if (load) begin
				cnt_s2 <= load_burst.count;
			end else if (pop) begin
				cnt_s2 <= cnt_s2 - stxf_pkg::CNT_W'(1);
			end
			if (pop) begin
				out_valid_s3 <= 1'b1;
			end else if (frame.ready) begin
				out_valid_s3 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_s2 <= load_burst.bytes;
			ends_s2  <= load_burst.ends;
		end else if (pop) begin
			bytes_s2 <= {8'h00, bytes_s2[stxf_pkg::BURST_DEPTH-1:1]};
			ends_s2  <= {1'b0, ends_s2[stxf_pkg::BURST_DEPTH-1:1]};
		end
		if (pop) begin
			out_byte_s3  <= bytes_s2[0];
			frame_end_s3 <= ends_s2[0];
		end
	end

	assign frame.valid     = out_valid_s3;
	assign frame.out_byte  = out_byte_s3;
	assign frame.frame_end = frame_end_s3;

endmodule

`default_nettype wire

### rtl/core/stx_frame_builder_xor_lrc.sv
// Top level of the STX frame builder with length framing and XOR LRC.
//
// Channels: item (sink) takes start items (action 0: command, frame_length,
// payload_absent) and data items (action 1: data_byte). frame (source) gives
// one frame byte per beat, with frame_end set on the closing LRC byte.
// A start item yields STX, command, length low, length high, and for a zero
// length (or absent payload) the LRC as well. A data item inside a frame yields
// its byte, followed by the LRC when it is the last one. A data item outside a
// frame is taken and yields nothing. The length is reduced modulo
// LENGTH_MODULUS by a reciprocal multiply ahead of the input register and a
// multiply-back with one correction after it.
// The first byte of an item passes the input register, the burst buffer and
// the output register on its way to frame. Throughput: one item per cycle as
// long as each item makes at most one byte and the receiver takes every beat;
// otherwise the block takes the next item in the cycle that the last byte of
// the current one moves to the output register.
// Reset clears the pipeline and leaves the block outside any frame. When the
// receiver stalls, the output byte holds, the burst buffer and input register
// fill, and item.ready drops.
`default_nettype none

module stx_frame_builder_xor_lrc #(
	parameter int unsigned LENGTH_MODULUS = 8096
) (
	input  wire         clk,
	input  wire         arst_n,
	stxf_in_if.sink     item,
	stxf_out_if.source  frame
);

	localparam longint unsigned RECIP_L = (64'd1 << 32) / LENGTH_MODULUS;
	localparam logic [31:0] RECIP = 32'(RECIP_L);
	localparam logic [15:0] MOD16 = 16'(LENGTH_MODULUS);
	localparam logic [29:0] MOD30 = 30'(LENGTH_MODULUS);

	localparam int LW = stxf_pkg::LEN_W;

	// Input register stage
	logic                s1_valid;
	stxf_pkg::action_t   action_s1;
	stxf_pkg::byte_t     command_s1;
	logic [15:0]         length_s1;
	logic [15:0]         quot_s1;
	logic                absent_s1;
	stxf_pkg::byte_t     data_s1;

	// Frame state
	stxf_pkg::byte_t     lrc_q;
	logic [LW-1:0]       remaining_q;
	logic                in_frame_q;

	logic                in_fire;
	logic                s1_adv;
	logic                burst_free;
	logic [47:0]         recip_prod;

	logic [29:0]         qm;
	logic [15:0]         rem_raw;
	logic [15:0]         rem_fix;
	logic [LW-1:0]       len_red;
	stxf_pkg::byte_t     len_lo;
	stxf_pkg::byte_t     len_hi;
	stxf_pkg::byte_t     lrc_start;
	stxf_pkg::byte_t     lrc_data;
	logic [LW-1:0]       rem_dec;

	stxf_pkg::burst_t    burst;
	stxf_pkg::byte_t     lrc_d;
	logic [LW-1:0]       remaining_d;
	logic                in_frame_d;

	assign s1_adv     = s1_valid && burst_free;
	assign item.ready = !s1_valid || s1_adv;
	assign in_fire    = item.valid && item.ready;

	// Quotient estimate; it is the true quotient or one less.
	assign recip_prod = {32'd0, item.frame_length} * {16'd0, RECIP};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid    <= 1'b0;
			lrc_q       <= '0;
			remaining_q <= '0;
			in_frame_q  <= 1'b0;
		end else begin
			if (in_fire) begin
				s1_valid <= 1'b1;
			end else if (s1_adv) begin
				s1_valid <= 1'b0;
			end
			if (s1_adv) begin
				lrc_q       <= lrc_d;
				remaining_q <= remaining_d;
				in_frame_q  <= in_frame_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			action_s1  <= stxf_pkg::action_t'(item.action);
			command_s1 <= item.command;
			length_s1  <= item.frame_length;
			quot_s1    <= recip_prod[47:32];
			absent_s1  <= item.payload_absent;
			data_s1    <= item.data_byte;
		end
	end

	// Remainder from the quotient estimate, with one correcting subtract.
	assign qm       = {14'd0, quot_s1} * MOD30;
	assign rem_raw  = length_s1 - qm[15:0];
	assign rem_fix  = (rem_raw >= MOD16) ? (rem_raw - MOD16) : rem_raw;
	assign len_red  = absent_s1 ? '0 : rem_fix[LW-1:0];
	assign len_lo   = len_red[7:0];
	assign len_hi   = {{(16 - LW){1'b0}}, len_red[LW-1:8]};

	assign lrc_start = command_s1 ^ len_lo ^ len_hi;
	assign lrc_data  = lrc_q ^ data_s1;
	assign rem_dec   = (remaining_q != '0) ? (remaining_q - LW'(1)) : remaining_q;

	always_comb begin
		burst       = '0;
		lrc_d       = lrc_q;
		remaining_d = remaining_q;
		in_frame_d  = in_frame_q;
		unique case (action_s1)
			stxf_pkg::ACT_START: begin
				burst.bytes[0] = stxf_pkg::STX_BYTE;
				burst.bytes[1] = command_s1;
				burst.bytes[2] = len_lo;
				burst.bytes[3] = len_hi;
				burst.bytes[4] = lrc_start;
				burst.ends[4]  = (len_red == '0);
				burst.count    = (len_red == '0) ? stxf_pkg::CNT_W'(5) : stxf_pkg::CNT_W'(4);
				lrc_d          = lrc_start;
				remaining_d    = len_red;
				in_frame_d     = (len_red != '0);
			end
			stxf_pkg::ACT_DATA: begin
				// Outside a frame the item is dropped and the state stays.
				if (in_frame_q) begin
					burst.bytes[0] = data_s1;
					burst.bytes[1] = lrc_data;
					burst.ends[1]  = (rem_dec == '0);
					burst.count    = (rem_dec == '0) ? stxf_pkg::CNT_W'(2) : stxf_pkg::CNT_W'(1);
					lrc_d          = lrc_data;
					remaining_d    = rem_dec;
					in_frame_d     = (rem_dec != '0);
				end
			end
			default: begin
				burst = '0;
			end
		endcase
	end

	stxf_byte_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (s1_adv),
		.load_burst (burst),
		.free       (burst_free),
		.frame      (frame)
	);

endmodule

`default_nettype wire

### rtl/core/stxf_checker.sv
// Port-level checker for the frame builder output, bound to the top level.
`default_nettype none

`include "stx_frame_builder_xor_lrc_assert.svh"

module stxf_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       out_valid,
	input wire       out_ready,
	input wire [7:0] out_byte,
	input wire       frame_end
);

	// A stalled beat stays offered.
	`STXF_ASSERT_NEXT(a_valid_hold, out_valid && !out_ready, out_valid, "stalled beat dropped")

	// A stalled beat keeps its byte and end mark.
	`STXF_ASSERT_NEXT(a_payload_hold, out_valid && !out_ready, $stable(out_byte) && $stable(frame_end), "stalled beat changed")

	// Every frame has a header before its LRC, so two closing beats never come back to back.
	`STXF_ASSERT_NEXT(a_no_double_end, out_valid && out_ready && frame_end, !(out_valid && out_ready && frame_end), "two LRC beats in a row")

endmodule

bind stx_frame_builder_xor_lrc stxf_checker u_stxf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (frame.valid),
	.out_ready (frame.ready),
	.out_byte  (frame.out_byte),
	.frame_end (frame.frame_end)
);

`default_nettype wire
